[src/chm_pkg.sv]
// Package: sizes, opcodes, status codes and the key hash for the chained hash table.
`default_nettype none
package chm_pkg;
    localparam int NUM_BUCKETS  = 256;
    localparam int POOL_ENTRIES = 1024;
    localparam int BKT_W   = $clog2(NUM_BUCKETS);
    localparam int IDX_W   = $clog2(POOL_ENTRIES);
    localparam int LINK_W  = IDX_W + 1;
    localparam int CNT_W   = 11;

    localparam logic [31:0] HASH_MUL = 32'h045d9f3b;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request word
        logic hash1;     // first xor-shift multiply
        logic hash2;     // second xor-shift multiply
        logic hash3;     // final xor-shift, bucket select
        logic head_rd;   // fetch bucket head
        logic ent_rd;    // read entry at cur
        logic step;      // advance cur / prev
        logic upd;       // write value at cur
        logic ins;       // allocate and push at head
        logic rem;       // unlink cur
        logic found;     // latch found value
        logic fin;       // load output register
        logic [2:0] status;
    } chm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       cur_end;   // cur is the end code
        logic       key_hit;   // entry key matches
        logic       can_alloc; // free stack or fresh pool available
    } chm_sts_t;
endpackage
`default_nettype wire

[src/chained_hash_map_u32_top.sv]
// Top level: chained hash table of 32-bit keys and values.
//
//  channel | dir | handshake          | word
//  in      | in  | in_valid/in_stall  | opcode, key, value
//  out     | out | out_valid/out_stall| status, found_value, entry_total
//
// After accept a request passes three hash states, the head read and a chain
// check; each entry passed over adds a read, a wait and a compare, and the
// matching entry is read and compared before the result. Unused opcode skips the walk.
// Reset clears bucket heads, free-stack top, fresh pointer and count.
// One request at a time; a stalled result holds the block in its last state.
`default_nettype none
module chained_hash_map_u32_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [31:0] key,
    input  wire logic [31:0] value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [31:0]      found_value,
    output logic [10:0]      entry_total
);
    import chm_pkg::*;

    chm_cmd_t cmd;
    chm_sts_t sts;

    chm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .sts(sts), .cmd(cmd)
    );

    chm_dp u_dp (
        .clk(clk), .rst_n(rst_n),
        .opcode(opcode), .key(key), .value(value),
        .cmd(cmd), .sts(sts),
        .status(status), .found_value(found_value), .entry_total(entry_total)
    );
endmodule
`default_nettype wire

[src/chm_ctrl.sv]
// Controller: state machine sequencing hash, chain walk and update.
`default_nettype none
module chm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire chm_pkg::chm_sts_t sts,
    output chm_pkg::chm_cmd_t      cmd
);
    import chm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_H1    = 4'd1;
    localparam logic [3:0] S_H2    = 4'd2;
    localparam logic [3:0] S_H3    = 4'd3;
    localparam logic [3:0] S_HEAD  = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       fin;

    assign out_valid = ovalid_reg;
    // output register may be reloaded once the old word is taken
    assign in_stall  = (state_reg != S_IDLE);

    // unused opcode skips the walk
    function automatic logic opcode_skip();
        return (state_reg == S_HEAD) && (sts.opcode == OP_UNUSED);
    endfunction

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_NOT_FOUND;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_H1;
                end
            end
            S_H1: begin cmd.hash1 = 1'b1; state_next = S_H2; end
            S_H2: begin cmd.hash2 = 1'b1; state_next = S_H3; end
            S_H3: begin cmd.hash3 = 1'b1; state_next = S_HEAD; end
            S_HEAD: begin cmd.head_rd = 1'b1; state_next = S_CHK; end
            S_CHK:
            begin
                if (sts.cur_end)
                begin
                    if (sts.opcode == OP_INSERT)
                    begin
                        if (sts.can_alloc)
                        begin
                            cmd.ins = 1'b1;
                            cmd.status = ST_INSERTED;
                        end
                        else
                            cmd.status = ST_FULL;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD: state_next = S_CMP;
            S_CMP:
            begin
                if (sts.key_hit)
                begin
                    unique case (sts.opcode)
                        OP_INSERT: begin cmd.upd = 1'b1; cmd.status = ST_UPDATED; end
                        OP_REMOVE: begin cmd.rem = 1'b1; cmd.status = ST_REMOVED; end
                        OP_LOOKUP: begin cmd.found = 1'b1; cmd.status = ST_FOUND; end
                        default:   cmd.status = ST_NOT_FOUND;
                    endcase
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_OUT:
            begin
                if (!(ovalid_reg && out_stall))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        // status is latched when decided; S_OUT moves it to the output
        fin = (state_reg == S_OUT) && !(ovalid_reg && out_stall);
        cmd.fin = fin;
        if (opcode_skip())
            state_next = S_OUT;
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;
        if (fin)
            ovalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fin |=> out_valid)
        else $error("result lost");
    a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ins || cmd.upd || cmd.rem) |-> !(cmd.step || cmd.ent_rd))
        else $error("write during walk step");
endmodule
`default_nettype wire

[src/chm_dp.sv]
// Datapath: hash, bucket heads, entry pool memories, free stack and result register.
`default_nettype none
module chm_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [1:0]        opcode,
    input  wire logic [31:0]       key,
    input  wire logic [31:0]       value,
    input  wire chm_pkg::chm_cmd_t cmd,
    output chm_pkg::chm_sts_t      sts,
    output logic [2:0]             status,
    output logic [31:0]            found_value,
    output logic [10:0]            entry_total
);
    import chm_pkg::*;

    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(POOL_ENTRIES);

    logic [1:0]        op_reg;
    logic [31:0]       key_reg, val_reg, h_reg;
    logic [BKT_W-1:0]  bkt_reg;
    logic [LINK_W-1:0] cur_reg, prev_reg;
    logic [2:0]        st_reg;
    logic [31:0]       fv_reg;

    logic [LINK_W-1:0] head_mem [NUM_BUCKETS];
    logic              head_vld [NUM_BUCKETS];
    logic [31:0]       key_mem  [POOL_ENTRIES];
    logic [31:0]       val_mem  [POOL_ENTRIES];
    logic [LINK_W-1:0] link_mem [POOL_ENTRIES];
    logic [IDX_W-1:0]  free_mem [POOL_ENTRIES];

    logic [31:0]       rd_key, rd_val;
    logic [LINK_W-1:0] rd_link;
    logic [IDX_W-1:0]  free_rd;
    logic [LINK_W-1:0] head_rd_reg;
    logic              head_vld_reg;
    logic [LINK_W-1:0] fs_top_reg, fresh_reg;
    logic [CNT_W-1:0]  live_reg;
    logic [2:0]        status_reg;
    logic [31:0]       found_reg;
    logic [CNT_W-1:0]  total_reg;

    logic [31:0] hx;
    logic [LINK_W-1:0] head_cur;
    logic [LINK_W-1:0] slot;
    logic              use_free;

    assign hx = (h_reg >> 16) ^ h_reg;
    // bucket head read with the bucket select, held for the whole walk
    assign head_cur = head_vld_reg ? head_rd_reg : LINK_END;
    assign use_free = (fs_top_reg != '0);
    assign slot = use_free ? {1'b0, free_rd} : fresh_reg;

    assign sts.opcode    = op_reg;
    assign sts.cur_end   = cur_reg[IDX_W];
    assign sts.key_hit   = (rd_key == key_reg);
    assign sts.can_alloc = use_free || (fresh_reg < LINK_END);

    assign status      = status_reg;
    assign found_value = found_reg;
    assign entry_total = total_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            key_reg <= key;
            val_reg <= value;
            h_reg   <= key;
            st_reg  <= ST_NOT_FOUND;
            fv_reg  <= '0;
        end
        if (cmd.hash1 || cmd.hash2)
            h_reg <= hx * HASH_MUL;
        if (cmd.hash3)
            bkt_reg <= hx[BKT_W-1:0];
        if (cmd.head_rd)
        begin
            cur_reg  <= head_cur;
            prev_reg <= LINK_END;
        end
        if (cmd.step)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= rd_link;
        end
        if (cmd.status != ST_NOT_FOUND)
            st_reg <= cmd.status;
        if (cmd.found)
            fv_reg <= rd_val;
        if (cmd.fin)
        begin
            status_reg <= st_reg;
            found_reg  <= fv_reg;
            total_reg  <= live_reg;
        end
    end

    // pool memories: one read port (entry at cur), one write port
    always_ff @(posedge clk)
    begin
        if (cmd.ent_rd)
        begin
            rd_key  <= key_mem[cur_reg[IDX_W-1:0]];
            rd_val  <= val_mem[cur_reg[IDX_W-1:0]];
            rd_link <= link_mem[cur_reg[IDX_W-1:0]];
        end
        if (cmd.upd)
            val_mem[cur_reg[IDX_W-1:0]] <= val_reg;
        if (cmd.ins)
        begin
            key_mem[slot[IDX_W-1:0]]  <= key_reg;
            val_mem[slot[IDX_W-1:0]]  <= val_reg;
            link_mem[slot[IDX_W-1:0]] <= head_cur;
        end
        if (cmd.rem && (prev_reg != LINK_END))
            link_mem[prev_reg[IDX_W-1:0]] <= rd_link;
    end

    // free stack: top entry read into a register ahead of the insert that pops it
    always_ff @(posedge clk)
    begin
        if (cmd.rem)
            free_mem[fs_top_reg[IDX_W-1:0]] <= cur_reg[IDX_W-1:0];
        free_rd <= free_mem[IDX_W'(fs_top_reg - LINK_W'(1))];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hash3)
        begin
            head_rd_reg  <= head_mem[hx[BKT_W-1:0]];
            head_vld_reg <= head_vld[hx[BKT_W-1:0]];
        end
        if (cmd.ins)
            head_mem[bkt_reg] <= slot;
        if (cmd.rem && (prev_reg == LINK_END))
            head_mem[bkt_reg] <= rd_link;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUCKETS; i++)
                head_vld[i] <= 1'b0;
            fs_top_reg <= '0;
            fresh_reg  <= '0;
            live_reg   <= '0;
        end
        else
        begin
            if (cmd.ins)
            begin
                head_vld[bkt_reg] <= 1'b1;
                live_reg <= live_reg + CNT_W'(1);
                if (use_free)
                    fs_top_reg <= fs_top_reg - LINK_W'(1);
                else
                    fresh_reg <= fresh_reg + LINK_W'(1);
            end
            if (cmd.rem)
            begin
                fs_top_reg <= fs_top_reg + LINK_W'(1);
                if (live_reg != '0)
                    live_reg <= live_reg - CNT_W'(1);
            end
        end
    end

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fs_top_reg <= fresh_reg)
        else $error("free stack deeper than pool used");
    a_live: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(fresh_reg) == live_reg + CNT_W'(fs_top_reg))
        else $error("live count out of step");
    a_ins_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |-> !slot[IDX_W])
        else $error("insert without free slot");
endmodule
`default_nettype wire
